### src/chbd_pkg.sv
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types, codes and character classes for the chunked body decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    typedef enum logic [6:0] {
        PH_SIZE     = 7'b000_0001,
        PH_DATA     = 7'b000_0010,
        PH_CRLF     = 7'b000_0100,
        PH_TRL      = 7'b000_1000,
        PH_TRL_SEEN = 7'b001_0000,
        PH_DONE     = 7'b010_0000,
        PH_ERR      = 7'b100_0000
    } phase_t;

    // size-line sub-phases
    localparam logic [2:0] SL_LEAD      = 3'd0;
    localparam logic [2:0] SL_DIGITS    = 3'd1;
    localparam logic [2:0] SL_TRAIL     = 3'd2;
    localparam logic [2:0] SL_EXT_EMPTY = 3'd3;
    localparam logic [2:0] SL_EXT_OK    = 3'd4;

    // trailer-line sub-phases
    localparam logic [2:0] TL_START     = 3'd0;
    localparam logic [2:0] TL_CONT      = 3'd1;
    localparam logic [2:0] TL_LEAD      = 3'd2;
    localparam logic [2:0] TL_NAME      = 3'd3;
    localparam logic [2:0] TL_TRAIL     = 3'd4;
    localparam logic [2:0] TL_BADN      = 3'd5;
    localparam logic [2:0] TL_COLON_OK  = 3'd6;
    localparam logic [2:0] TL_COLON_BAD = 3'd7;

    // delimiter sub-phases after chunk data
    localparam logic [2:0] CD_FIRST     = 3'd0;
    localparam logic [2:0] CD_SECOND    = 3'd1;

    // size-line fault marks
    localparam logic [1:0] LB_NONE      = 2'd0;
    localparam logic [1:0] LB_BADCHAR   = 2'd1;
    localparam logic [1:0] LB_OVERFLOW  = 2'd2;

    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_HT    = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_CTL_MAX = 8'd31;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_ERROR      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_EMPTY_SIZE = 3'd1,
        ERR_BAD_SIZE   = 3'd2,
        ERR_BAD_DELIM  = 3'd3,
        ERR_MALFORMED  = 3'd4,
        ERR_BAD_NAME   = 3'd5,
        ERR_OVERFLOW   = 3'd6
    } err_t;

    typedef struct packed {
        logic       new_message;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        status_t    status;
        err_t       error_code;
    } res_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_HT) || (b == CH_CR) || (b == CH_LF);
    endfunction

    // {is_hex, value}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd0;
        if (b >= "0" && b <= "9") begin
            return {1'b1, b[3:0]};
        end else if (b >= "a" && b <= "f") begin
            d = b - "a" + 8'd10;
            return {1'b1, d[3:0]};
        end else if (b >= "A" && b <= "F") begin
            d = b - "A" + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic is_token_char(input logic [7:0] b);
        if (b <= CH_CTL_MAX || b == CH_DEL) begin
            return 1'b0;
        end
        case (b) inside
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
            "[", "]", "?", "=", "{", "}", CH_SP, CH_HT: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

endpackage

### src/chbd_in_reg.sv
// ----------------------------------------------------------------------------
// chbd_in_reg
// Input register: holds one request until the decode step takes it.
// ----------------------------------------------------------------------------
module chbd_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic           s_tuser,
    input  logic           out_ready,
    output logic           fire,
    output chbd_pkg::item_t item
);
    import chbd_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign fire     = valid_reg && out_ready;
    assign s_tready = !valid_reg || out_ready;
    assign item     = item_reg;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= '{new_message: s_tuser, data_byte: s_tdata};
        end
    end

endmodule

### src/chbd_engine.sv
// ----------------------------------------------------------------------------
// chbd_engine
// Decoder state and the per-byte step: size line, chunk data, delimiter,
// trailer lines.
// ----------------------------------------------------------------------------
module chbd_engine #(
    parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           fire,
    input  chbd_pkg::item_t item,
    output chbd_pkg::res_t  res
);
    import chbd_pkg::*;

    typedef struct packed {
        logic [2:0]           lp;
        logic [1:0]           lbad;
        logic [SIZE_BITS-1:0] acc;
    } line_t;

    localparam logic [SIZE_BITS-1:0] ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

    logic                 header_name_seen_reg;
    phase_t               phase_reg, phase_next;
    line_t                line_reg, line_next;
    logic                 pending_cr_reg, pending_cr_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;
    err_t                 latched_error_reg, latched_error_next;
    logic                 named;
    logic [2:0]           prev_lp;
    logic [7:0]           b;

    function automatic line_t size_char(input line_t st, input logic [7:0] c);
        line_t      r;
        logic [4:0] h;
        r = st;
        h = hex_val(c);
        if (st.lp == SL_EXT_EMPTY || st.lp == SL_EXT_OK) begin
            return r;
        end
        if (c == CH_SEMI) begin
            r.lp = (st.lp == SL_LEAD) ? SL_EXT_EMPTY : SL_EXT_OK;
        end else if (is_ws(c)) begin
            if (st.lp == SL_DIGITS) r.lp = SL_TRAIL;
        end else if (h[4] && st.lp != SL_TRAIL) begin
            r.lp = SL_DIGITS;
            if (st.lbad == LB_NONE) begin
                if (st.acc[SIZE_BITS-1 -: 4] != 4'd0) begin
                    r.lbad = LB_OVERFLOW;
                end else begin
                    r.acc = {st.acc[SIZE_BITS-5:0], h[3:0]};
                end
            end
        end else begin
            if (st.lbad == LB_NONE) r.lbad = LB_BADCHAR;
            r.lp = SL_TRAIL;
        end
        return r;
    endfunction

    function automatic logic [2:0] trailer_char(input logic [2:0] lp, input logic [7:0] c);
        logic [2:0] p;
        p = lp;
        if (p == TL_START) begin
            if (c == CH_SP || c == CH_HT) return TL_CONT;
            p = TL_LEAD;
        end
        if (p == TL_CONT || p == TL_COLON_OK || p == TL_COLON_BAD) return p;
        if (c == CH_COLON) begin
            return (p == TL_NAME || p == TL_TRAIL) ? TL_COLON_OK : TL_COLON_BAD;
        end
        if (p == TL_BADN) return p;
        if (is_ws(c)) begin
            return (p == TL_NAME) ? TL_TRAIL : p;
        end
        if (is_token_char(c) && p != TL_TRAIL) return TL_NAME;
        return TL_BADN;
    endfunction

    function automatic line_t line_char(input phase_t ph, input line_t st,
                                        input logic [7:0] c);
        line_t r;
        r = st;
        if (ph == PH_SIZE) begin
            r = size_char(st, c);
        end else begin
            r.lp = trailer_char(st.lp, c);
        end
        return r;
    endfunction

    assign b = item.data_byte;

    always_comb begin
        phase_next         = phase_reg;
        line_next          = line_reg;
        pending_cr_next    = pending_cr_reg;
        bytes_left_next    = bytes_left_reg;
        latched_error_next = latched_error_reg;
        named              = 1'b0;
        prev_lp            = TL_START;
        res                = '{body_valid: 1'b0, body_byte: 8'd0,
                               status: ST_INCOMPLETE, error_code: ERR_NONE};

        if (item.new_message) begin
            phase_next         = PH_SIZE;
            line_next          = '0;
            pending_cr_next    = 1'b0;
            bytes_left_next    = '0;
            latched_error_next = ERR_NONE;
        end

        unique case (phase_next)
            PH_SIZE, PH_TRL, PH_TRL_SEEN: begin
                if (pending_cr_next && b == CH_LF) begin
                    pending_cr_next = 1'b0;
                    if (phase_next == PH_SIZE) begin
                        if (line_next.lp == SL_LEAD || line_next.lp == SL_EXT_EMPTY) begin
                            phase_next         = PH_ERR;
                            latched_error_next = ERR_EMPTY_SIZE;
                        end else if (line_next.lbad == LB_BADCHAR) begin
                            phase_next         = PH_ERR;
                            latched_error_next = ERR_BAD_SIZE;
                        end else if (line_next.lbad == LB_OVERFLOW) begin
                            phase_next         = PH_ERR;
                            latched_error_next = ERR_OVERFLOW;
                        end else if (line_next.acc == '0) begin
                            phase_next = PH_TRL;
                        end else begin
                            bytes_left_next = line_next.acc;
                            phase_next      = PH_DATA;
                        end
                        line_next = '0;
                    end else begin
                        named        = (phase_next == PH_TRL_SEEN) || header_name_seen_reg;
                        prev_lp      = line_next.lp;
                        line_next.lp = TL_START;
                        case (prev_lp)
                            TL_START:     phase_next = PH_DONE;
                            TL_CONT: begin
                                if (named) begin
                                    phase_next = PH_TRL_SEEN;
                                end else begin
                                    phase_next         = PH_ERR;
                                    latched_error_next = ERR_MALFORMED;
                                end
                            end
                            TL_COLON_OK:  phase_next = PH_TRL_SEEN;
                            TL_COLON_BAD: begin
                                phase_next         = PH_ERR;
                                latched_error_next = ERR_BAD_NAME;
                            end
                            default: begin
                                phase_next         = PH_ERR;
                                latched_error_next = ERR_MALFORMED;
                            end
                        endcase
                    end
                end else begin
                    // lone CR counts as an ordinary line byte
                    if (pending_cr_next) begin
                        pending_cr_next = 1'b0;
                        line_next       = line_char(phase_next, line_next, CH_CR);
                    end
                    if (b == CH_CR) begin
                        pending_cr_next = 1'b1;
                    end else begin
                        line_next = line_char(phase_next, line_next, b);
                    end
                end
            end
            PH_DATA: begin
                res.body_valid  = 1'b1;
                res.body_byte   = b;
                bytes_left_next = bytes_left_next - ONE;
                if (bytes_left_next == '0) begin
                    phase_next      = PH_CRLF;
                    line_next.lp    = CD_FIRST;
                    pending_cr_next = 1'b0;
                end
            end
            PH_CRLF: begin
                if (line_next.lp == CD_FIRST) begin
                    pending_cr_next = (b == CH_CR);
                    line_next.lp    = CD_SECOND;
                end else begin
                    line_next.lp = CD_FIRST;
                    if (pending_cr_next && b == CH_LF) begin
                        phase_next = PH_SIZE;
                    end else begin
                        phase_next         = PH_ERR;
                        latched_error_next = ERR_BAD_DELIM;
                    end
                    pending_cr_next = 1'b0;
                end
            end
            PH_DONE, PH_ERR: begin
            end
            default: begin
            end
        endcase

        if (phase_next == PH_DONE) begin
            res.status = ST_COMPLETE;
        end else if (phase_next == PH_ERR) begin
            res.status     = ST_ERROR;
            res.error_code = latched_error_next;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            header_name_seen_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            header_name_seen_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            phase_reg         <= PH_SIZE;
            line_reg          <= '0;
            pending_cr_reg    <= 1'b0;
            bytes_left_reg    <= '0;
            latched_error_reg <= ERR_NONE;
        end else if (fire) begin
            phase_reg         <= phase_next;
            line_reg          <= line_next;
            pending_cr_reg    <= pending_cr_next;
            bytes_left_reg    <= bytes_left_next;
            latched_error_reg <= latched_error_next;
        end
    end

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.new_message && phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("completed message left done without restart");

    a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.new_message && phase_reg == PH_ERR)
        |=> (phase_reg == PH_ERR && $stable(latched_error_reg)))
        else $error("error state changed without restart");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_next == PH_DATA) |=> (bytes_left_reg != '0))
        else $error("data phase with zero bytes left");

    a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg))
        else $error("phase moved without a request");

    a_data_out: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.new_message && phase_reg == PH_DATA) |-> res.body_valid)
        else $error("chunk data byte not passed out");

endmodule

### src/chbd_out_reg.sv
// ----------------------------------------------------------------------------
// chbd_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module chbd_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  chbd_pkg::res_t res,
    output logic           out_ready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic [5:0]     m_tuser
);
    import chbd_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign out_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = res_reg.body_byte;
    assign m_tuser   = {res_reg.error_code, res_reg.status, res_reg.body_valid};

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (fire) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

endmodule

### src/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// HTTP/1.1 chunked body decoder, one byte in and one result out per request.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle and returns one result per byte; each byte
// passes the input register, then the decode step into the result register.
// The whole per-byte step (size-line parse with shift-add, data countdown,
// delimiter and trailer checks) is combinational between the two registers, so
// the sustained rate is one byte per clock as long as the result side takes
// results; a stalled result stops the input only once both registers are
// full. No memories, no clearing pass after reset. Write cfg_wr_data
// (header_name_seen) only while no request is in flight.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,   // header_name_seen
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] data_byte
    input  logic       s_tuser,       // [0] new_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] body_byte
    output logic [5:0] m_tuser        // [0] body_valid, [2:1] status, [5:3] error_code
);
    import chbd_pkg::*;

    logic  fire;
    logic  out_ready;
    item_t item;
    res_t  res;

    chbd_in_reg u_in_reg (
        .clk       (aclk),
        .rst_n     (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .out_ready (out_ready),
        .fire      (fire),
        .item      (item)
    );

    chbd_engine #(
        .SIZE_BITS (SIZE_BITS)
    ) u_engine (
        .clk         (aclk),
        .rst_n       (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (item),
        .res         (res)
    );

    chbd_out_reg u_out_reg (
        .clk       (aclk),
        .rst_n     (aresetn),
        .fire      (fire),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### tb/chunked_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunked_decode_checker
// Watches both streams of the chunked body decoder, predicts one result per
// accepted request from its own copy of the decode state and compares every
// accepted result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module chunked_decode_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [5:0] m_tuser,
    output int         fail_count,
    output int         outstanding
);
    import chbd_pkg::*;

    phase_t      phase;
    logic [2:0]  sub_phase;
    logic        cr_held;
    logic [1:0]  size_fault;
    logic [31:0] size_acc;
    logic [31:0] body_left;
    err_t        err_latched;
    logic        hdr_name_seen;

    res_t predicted_results[$];
    int   mismatches;

    function automatic bit blank(input logic [7:0] c);
        return c == CH_SP || c == CH_HT || c == CH_CR || c == CH_LF;
    endfunction

    function automatic int nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        return -1;
    endfunction

    function automatic bit token_byte(input logic [7:0] c);
        if (c <= CH_CTL_MAX || c == CH_DEL) return 1'b0;
        case (c)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
            "[", "]", "?", "=", "{", "}", CH_SP, CH_HT: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    function automatic void restart_message();
        phase       = PH_SIZE;
        sub_phase   = SL_LEAD;
        cr_held     = 1'b0;
        size_fault  = LB_NONE;
        size_acc    = '0;
        body_left   = '0;
        err_latched = ERR_NONE;
    endfunction

    function automatic void abort(input err_t code);
        phase       = PH_ERR;
        err_latched = code;
    endfunction

    function automatic void size_char(input logic [7:0] c);
        int h;
        h = nibble(c);
        if (sub_phase == SL_EXT_EMPTY || sub_phase == SL_EXT_OK) return;
        if (c == CH_SEMI) begin
            sub_phase = (sub_phase == SL_LEAD) ? SL_EXT_EMPTY : SL_EXT_OK;
            return;
        end
        if (blank(c)) begin
            if (sub_phase == SL_DIGITS) sub_phase = SL_TRAIL;
            return;
        end
        if (h >= 0 && sub_phase != SL_TRAIL) begin
            sub_phase = SL_DIGITS;
            if (size_fault == LB_NONE) begin
                if (size_acc[31:28] != 4'd0) size_fault = LB_OVERFLOW;
                else size_acc = {size_acc[27:0], 4'(h)};
            end
            return;
        end
        if (size_fault == LB_NONE) size_fault = LB_BADCHAR;
        sub_phase = SL_TRAIL;
    endfunction

    function automatic void close_size_line();
        if (sub_phase == SL_LEAD || sub_phase == SL_EXT_EMPTY) abort(ERR_EMPTY_SIZE);
        else if (size_fault == LB_BADCHAR) abort(ERR_BAD_SIZE);
        else if (size_fault == LB_OVERFLOW) abort(ERR_OVERFLOW);
        else if (size_acc == 32'd0) phase = PH_TRL;
        else begin
            body_left = size_acc;
            phase     = PH_DATA;
        end
        sub_phase  = SL_LEAD;
        size_fault = LB_NONE;
        size_acc   = '0;
    endfunction

    function automatic void trailer_char(input logic [7:0] c);
        if (sub_phase == TL_START) begin
            if (c == CH_SP || c == CH_HT) begin
                sub_phase = TL_CONT;
                return;
            end
            sub_phase = TL_LEAD;
        end
        if (sub_phase == TL_CONT || sub_phase == TL_COLON_OK || sub_phase == TL_COLON_BAD)
            return;
        if (c == CH_COLON) begin
            sub_phase = (sub_phase == TL_NAME || sub_phase == TL_TRAIL) ?
                        TL_COLON_OK : TL_COLON_BAD;
            return;
        end
        if (sub_phase == TL_BADN) return;
        if (blank(c)) begin
            if (sub_phase == TL_NAME) sub_phase = TL_TRAIL;
            return;
        end
        if (token_byte(c) && sub_phase != TL_TRAIL) sub_phase = TL_NAME;
        else sub_phase = TL_BADN;
    endfunction

    function automatic void close_trailer_line();
        logic       named;
        logic [2:0] was;
        named     = (phase == PH_TRL_SEEN) || hdr_name_seen;
        was       = sub_phase;
        sub_phase = TL_START;
        case (was)
            TL_START:     phase = PH_DONE;
            TL_CONT:      if (named) phase = PH_TRL_SEEN; else abort(ERR_MALFORMED);
            TL_COLON_OK:  phase = PH_TRL_SEEN;
            TL_COLON_BAD: abort(ERR_BAD_NAME);
            default:      abort(ERR_MALFORMED);
        endcase
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        if (phase == PH_SIZE) size_char(c);
        else trailer_char(c);
    endfunction

    // CR is held back one byte so that only a CR LF pair ends a line
    function automatic void feed_line_byte(input logic [7:0] c);
        if (cr_held) begin
            cr_held = 1'b0;
            if (c == CH_LF) begin
                if (phase == PH_SIZE) close_size_line();
                else close_trailer_line();
                return;
            end
            scan_char(CH_CR);
        end
        if (c == CH_CR) cr_held = 1'b1;
        else scan_char(c);
    endfunction

    function automatic res_t decode_byte(input logic [7:0] c, input logic restart);
        res_t r;
        logic ok;
        r.body_valid = 1'b0;
        r.body_byte  = 8'd0;
        r.status     = ST_INCOMPLETE;
        r.error_code = ERR_NONE;
        if (restart) restart_message();
        case (phase)
            PH_SIZE, PH_TRL, PH_TRL_SEEN: feed_line_byte(c);
            PH_DATA: begin
                r.body_valid = 1'b1;
                r.body_byte  = c;
                body_left    = body_left - 32'd1;
                if (body_left == 32'd0) begin
                    phase     = PH_CRLF;
                    sub_phase = CD_FIRST;
                    cr_held   = 1'b0;
                end
            end
            PH_CRLF: begin
                if (sub_phase == CD_FIRST) begin
                    cr_held   = (c == CH_CR);
                    sub_phase = CD_SECOND;
                end else begin
                    ok        = cr_held && (c == CH_LF);
                    cr_held   = 1'b0;
                    sub_phase = CD_FIRST;
                    if (ok) phase = PH_SIZE;
                    else abort(ERR_BAD_DELIM);
                end
            end
            default: ;
        endcase
        if (phase == PH_DONE) r.status = ST_COMPLETE;
        else if (phase == PH_ERR) begin
            r.status     = ST_ERROR;
            r.error_code = err_latched;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t       want;
        logic [1:0] got_status;
        logic [2:0] got_err;
        if (!aresetn) begin
            restart_message();
            hdr_name_seen = 1'b1;
            predicted_results.delete();
            mismatches = 0;
        end else begin
            if (cfg_wr_en) hdr_name_seen = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got_status = m_tuser[2:1];
                got_err    = m_tuser[5:3];
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: tdata=%02h tuser=%02h", m_tdata, m_tuser);
                end else begin
                    want = predicted_results.pop_front();
                    if (m_tuser[0] !== want.body_valid || m_tdata !== want.body_byte ||
                        got_status !== want.status || got_err !== want.error_code) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp v=%0d b=%02h s=%0d e=%0d got v=%0d b=%02h s=%0d e=%0d",
                                     want.body_valid, want.body_byte, want.status,
                                     want.error_code, m_tuser[0], m_tdata, got_status,
                                     got_err);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predicted_results.insert(predicted_results.size(),
                                         decode_byte(s_tdata, s_tuser));
        end
        outstanding <= predicted_results.size();
        fail_count  <= mismatches;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the chunked body decoder: directed edge cases, then random
// chunked messages (clean, corrupted and noise) under several idling mixes,
// with a long receiver hold-off to back up the input. Checking is done by
// chunked_decode_checker; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import chbd_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'd0;
    logic       s_tuser     = 1'b0;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;
    logic [5:0] m_tuser;

    int fail_count;
    int outstanding;

    int send_idle  = 0;
    int recv_stall = 0;
    bit hold_req   = 1'b0;
    int items_sent = 0;

    logic [7:0] burst[$];
    string      tok_chars   = "abcdefxyzABCQ0129-_.!#$%&'*+^|~";
    string      noise_chars = "0123456789abcdefG;: \t";

    http_chunked_body_decoder u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    chunked_decode_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic nm);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= nm;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_burst(input logic nm);
        foreach (burst[i]) send_byte(burst[i], (i == 0) ? nm : 1'b0);
        burst.delete();
    endtask

    task automatic add_byte(input logic [7:0] c);
        burst.insert(burst.size(), c);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_line(input string s);
        add_text(s);
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    task automatic add_token(input int n);
        repeat (n) add_byte(tok_chars[$urandom_range(tok_chars.len() - 1)]);
    endtask

    task automatic add_size_line(input int n);
        logic [7:0] digits[$];
        int         v;
        int         d;
        bit         upper;
        v     = n;
        upper = $urandom_range(1);
        do begin
            d = v % 16;
            digits.push_front(d < 10 ? 8'(48 + d) : 8'((upper ? 55 : 87) + d));
            v = v / 16;
        end while (v != 0);
        repeat ($urandom_range(2)) digits.push_front("0");
        if ($urandom_range(3) == 0) add_byte($urandom_range(1) ? CH_SP : CH_HT);
        foreach (digits[i]) add_byte(digits[i]);
        if ($urandom_range(3) == 0) add_byte(CH_SP);
        if ($urandom_range(3) == 0) add_text(";ext=1");
        add_line("");
    endtask

    task automatic build_message();
        int size;
        repeat ($urandom_range(3)) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            add_size_line(size);
            repeat (size) add_byte(8'($urandom_range(255)));
            add_line("");
        end
        add_size_line(0);
        repeat ($urandom_range(2)) begin
            if ($urandom_range(3) == 0) begin
                add_byte($urandom_range(1) ? CH_SP : CH_HT);
                add_token($urandom_range(3));
            end else begin
                add_token($urandom_range(4, 1));
                if ($urandom_range(3) == 0) add_byte(CH_SP);
                add_byte(CH_COLON);
                repeat ($urandom_range(4)) add_byte(8'($urandom_range(126, 32)));
            end
            add_line("");
        end
        add_line("");
    endtask

    task automatic random_traffic(input int count);
        int target;
        int kind;
        int idx;
        target = items_sent + count;
        while (items_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 85) begin
                build_message();
                if (kind >= 70) begin
                    idx = $urandom_range(burst.size() - 1);
                    burst[idx] = 8'($urandom_range(255));
                    if ($urandom_range(2) == 0)
                        burst = burst[0:idx];
                end
            end else begin
                if ($urandom_range(3) == 0) add_line("fedcba987");
                repeat ($urandom_range(12, 1)) begin
                    if ($urandom_range(1))
                        add_byte(noise_chars[$urandom_range(noise_chars.len() - 1)]);
                    else
                        add_byte(8'($urandom_range(255)));
                end
            end
            send_burst($urandom_range(9) != 0);
        end
    endtask

    // register writes only once every request has come back
    task automatic set_header_seen(input logic v);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // clean message with extreme body bytes, then bytes after completion
        add_line("2");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_line("");
        add_line("0");
        add_line("");
        send_burst(1'b1);
        add_text("zz");
        send_burst(1'b0);
        add_line("");
        send_burst(1'b1);
        add_line(" ;x");
        send_burst(1'b1);
        add_line("g1");
        send_burst(1'b1);
        add_line("123456789");
        send_burst(1'b1);
        add_line("1");
        add_text("ABC");
        send_burst(1'b1);
        add_line("0");
        add_line("ab");
        send_burst(1'b1);
        add_line("0");
        add_line(" :v");
        add_line("");
        send_burst(1'b1);
        add_line("0");
        add_line("@:v");
        send_burst(1'b1);
        // lone CR inside a size line, trailer name with space before colon
        add_text("1");
        add_byte(CH_CR);
        add_line("");
        add_text("Q");
        add_line("");
        add_line("0");
        add_line("X-y : v");
        add_line("");
        send_burst(1'b1);

        set_header_seen(1'b0);
        add_line("0");
        add_line(" x");
        send_burst(1'b1);
        add_line("0");
        add_line("A:b");
        add_byte(CH_HT);
        add_line("c");
        add_line("");
        send_burst(1'b1);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 68; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 68; end
                default: begin send_idle = 24; recv_stall = 24; end
            endcase
            set_header_seen((p == 3) ? logic'($urandom_range(1)) : logic'(p % 2 == 0));
            if (p == 0) begin
                hold_req = 1'b1;
                build_message();
                build_message();
                send_burst(1'b1);
                wait (!hold_req);
            end
            random_traffic(85);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
